// ===== hdl/usk_pkg.sv =====
package usk_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int HANDLE_BITS  = 16;
	localparam int CONTEXT_BITS = 32;
	localparam int DEPTH_W      = 5;

	localparam logic [1:0] CMD_PUSH     = 2'd0;
	localparam logic [1:0] CMD_ROLLBACK = 2'd1;
	localparam logic [1:0] CMD_COMMIT   = 2'd2;
	localparam logic [1:0] CMD_DISPOSE  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	typedef struct packed {
		logic [1:0]              command;
		logic [HANDLE_BITS-1:0]  handler_id;
		logic [CONTEXT_BITS-1:0] context_key;
	} cmd_t;

	typedef struct packed {
		logic                    invoke;
		logic [HANDLE_BITS-1:0]  run_handler;
		logic [CONTEXT_BITS-1:0] run_context;
		logic [1:0]              status;
		logic                    last;
		logic [DEPTH_W-1:0]      depth;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RB_WAIT,
		S_RB_EMIT,
		S_DS_WAIT,
		S_DS_CMP,
		S_SH_WAIT,
		S_SH_WR
	} state_t;

endpackage

// ===== hdl/undo_stack_with_keyed_removal.sv =====
// Push, commit, and rollback/dispose on an empty stack: result in the next cycle.
// Rollback: per stored entry, a read then a result, top first; one result per entry.
// Dispose: per entry scanned from the top, a read and a compare; then, per entry moved
// down to close the gap, a read and a write. The waits come from the registered RAM read.
// busy is high until the last result is issued; results are one-cycle strobes on done.
// Reset (arst_n low) empties the stack; stored entries are not cleared.
module undo_stack_with_keyed_removal #(
	parameter int DEPTH = usk_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  usk_pkg::cmd_t cmd,
	output logic          done,
	output usk_pkg::res_t res
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = usk_pkg::DEPTH_W;
	localparam int HB = usk_pkg::HANDLE_BITS;
	localparam int CB = usk_pkg::CONTEXT_BITS;

	usk_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CB-1:0] key_q;
	logic [HB-1:0] found_hnd_q;
	logic [CB-1:0] found_ctx_q;

	logic [HB-1:0] hnd_mem [DEPTH];
	logic [CB-1:0] ctx_mem [DEPTH];
	logic [HB-1:0] rd_hnd_q;
	logic [CB-1:0] rd_ctx_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [HB-1:0] mem_whnd;
	logic [CB-1:0] mem_wctx;
	logic [AW-1:0] rd_addr;

	logic          emit;
	usk_pkg::res_t emit_res;
	logic          done_q;
	usk_pkg::res_t res_q;

	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] top_idx;
	logic [CW-1:0] idx_ext;
	logic          empty;
	logic          full;
	logic          key_hit;
	logic          at_top;
	logic          shift_last;

	assign cnt_m1     = count_q - 1'b1;
	assign top_idx    = cnt_m1[AW-1:0];
	assign idx_ext    = CW'(idx_q);
	assign empty      = (count_q == '0);
	assign full       = (count_q == CW'(DEPTH));
	assign key_hit    = (rd_ctx_q == key_q);
	assign at_top     = (idx_ext == cnt_m1);
	assign shift_last = ((idx_ext + 1'b1) == cnt_m1);

	assign busy = (state_q != usk_pkg::S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			usk_pkg::S_IDLE: begin
				if (start) begin
					if (cmd.command == usk_pkg::CMD_ROLLBACK && !empty)
						state_d = usk_pkg::S_RB_WAIT;
					else if (cmd.command == usk_pkg::CMD_DISPOSE && !empty)
						state_d = usk_pkg::S_DS_WAIT;
				end
			end
			usk_pkg::S_RB_WAIT: state_d = usk_pkg::S_RB_EMIT;
			usk_pkg::S_RB_EMIT: begin
				state_d = (idx_q == '0) ? usk_pkg::S_IDLE : usk_pkg::S_RB_WAIT;
			end
			usk_pkg::S_DS_WAIT: state_d = usk_pkg::S_DS_CMP;
			usk_pkg::S_DS_CMP: begin
				if (key_hit)
					state_d = at_top ? usk_pkg::S_IDLE : usk_pkg::S_SH_WAIT;
				else
					state_d = (idx_q == '0) ? usk_pkg::S_IDLE : usk_pkg::S_DS_WAIT;
			end
			usk_pkg::S_SH_WAIT: state_d = usk_pkg::S_SH_WR;
			usk_pkg::S_SH_WR: begin
				state_d = shift_last ? usk_pkg::S_IDLE : usk_pkg::S_SH_WAIT;
			end
			default: state_d = usk_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_whnd  = rd_hnd_q;
		mem_wctx  = rd_ctx_q;
		rd_addr   = idx_q;
		emit      = 1'b0;
		emit_res  = '0;
		emit_res.last  = 1'b1;
		emit_res.depth = DW'(count_q);
		count_d   = count_q;
		idx_d     = idx_q;
		case (state_q)
			usk_pkg::S_IDLE: begin
				idx_d = top_idx;
				if (start) begin
					emit = 1'b1;
					case (cmd.command)
						usk_pkg::CMD_PUSH: begin
							if (cmd.handler_id == '0) begin
								emit_res.status = usk_pkg::ST_INVALID;
							end else if (full) begin
								emit_res.status = usk_pkg::ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_whnd  = cmd.handler_id;
								mem_wctx  = cmd.context_key;
								count_d   = count_q + 1'b1;
								emit_res.depth = DW'(count_q + 1'b1);
							end
						end
						usk_pkg::CMD_ROLLBACK: begin
							emit = empty;
						end
						usk_pkg::CMD_COMMIT: begin
							count_d = '0;
							emit_res.depth = '0;
						end
						usk_pkg::CMD_DISPOSE: begin
							emit = empty;
							emit_res.status = usk_pkg::ST_NOMATCH;
						end
						default: emit = 1'b0;
					endcase
				end
			end
			usk_pkg::S_RB_EMIT: begin
				emit = 1'b1;
				emit_res.invoke      = (rd_hnd_q != '0);
				emit_res.run_handler = rd_hnd_q;
				emit_res.run_context = rd_ctx_q;
				emit_res.last        = (idx_q == '0);
				emit_res.depth       = DW'(cnt_m1);
				count_d = cnt_m1;
				idx_d   = idx_q - 1'b1;
			end
			usk_pkg::S_DS_CMP: begin
				if (key_hit) begin
					if (at_top) begin
						emit = 1'b1;
						emit_res.invoke      = (rd_hnd_q != '0);
						emit_res.run_handler = rd_hnd_q;
						emit_res.run_context = rd_ctx_q;
						emit_res.depth       = DW'(cnt_m1);
						count_d = cnt_m1;
					end
				end else begin
					idx_d = idx_q - 1'b1;
					if (idx_q == '0) begin
						emit = 1'b1;
						emit_res.status = usk_pkg::ST_NOMATCH;
					end
				end
			end
			usk_pkg::S_SH_WAIT: begin
				rd_addr = idx_q + 1'b1;
			end
			usk_pkg::S_SH_WR: begin
				// move entry idx+1 down into idx
				mem_we = 1'b1;
				idx_d  = idx_q + 1'b1;
				if (shift_last) begin
					emit = 1'b1;
					emit_res.invoke      = (found_hnd_q != '0);
					emit_res.run_handler = found_hnd_q;
					emit_res.run_context = found_ctx_q;
					emit_res.depth       = DW'(cnt_m1);
					count_d = cnt_m1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usk_pkg::S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (emit)
			res_q <= emit_res;
		if (state_q == usk_pkg::S_IDLE && start)
			key_q <= cmd.context_key;
		if (state_q == usk_pkg::S_DS_CMP) begin
			found_hnd_q <= rd_hnd_q;
			found_ctx_q <= rd_ctx_q;
		end
	end

	// stack RAM, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hnd_mem[mem_waddr] <= mem_whnd;
			ctx_mem[mem_waddr] <= mem_wctx;
		end
		rd_hnd_q <= hnd_mem[rd_addr];
		rd_ctx_q <= ctx_mem[rd_addr];
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 100;
	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_ITEMS   = 60;
	localparam logic [usk_pkg::CONTEXT_BITS-1:0] DUP_KEY = 32'h5A5A_5A5A;

	class undo_shadow;
		logic [usk_pkg::HANDLE_BITS-1:0]  saved_handler [usk_pkg::DEPTH_DEF];
		logic [usk_pkg::CONTEXT_BITS-1:0] saved_context [usk_pkg::DEPTH_DEF];
		int                               fill;
		usk_pkg::res_t                    queued_outcomes [$];
		int unsigned                      fail_count;

		function new();
			fill = 0;
			fail_count = 0;
		endfunction

		function void post(logic inv, logic [usk_pkg::HANDLE_BITS-1:0] h,
				logic [usk_pkg::CONTEXT_BITS-1:0] k, logic [1:0] st, logic lst);
			usk_pkg::res_t r;
			r.invoke      = inv;
			r.run_handler = h;
			r.run_context = k;
			r.status      = st;
			r.last        = lst;
			r.depth       = usk_pkg::DEPTH_W'(fill);
			queued_outcomes.push_back(r);
		endfunction

		function string describe(usk_pkg::res_t r);
			return $sformatf("inv=%0d hnd=%h ctx=%h st=%0d last=%0d depth=%0d",
				r.invoke, r.run_handler, r.run_context, r.status, r.last, r.depth);
		endfunction

		function void note_command(usk_pkg::cmd_t c);
			int                               p;
			logic [usk_pkg::HANDLE_BITS-1:0]  h;
			logic [usk_pkg::CONTEXT_BITS-1:0] k;
			case (c.command)
			usk_pkg::CMD_PUSH: begin
				if (c.handler_id == '0)
					post(1'b0, '0, '0, usk_pkg::ST_INVALID, 1'b1);
				else if (fill >= usk_pkg::DEPTH_DEF)
					post(1'b0, '0, '0, usk_pkg::ST_FULL, 1'b1);
				else begin
					saved_handler[fill] = c.handler_id;
					saved_context[fill] = c.context_key;
					fill++;
					post(1'b0, '0, '0, usk_pkg::ST_OK, 1'b1);
				end
			end
			usk_pkg::CMD_ROLLBACK: begin
				if (fill == 0)
					post(1'b0, '0, '0, usk_pkg::ST_OK, 1'b1);
				// one beat per entry, top first, depth counting down
				while (fill > 0) begin
					fill--;
					post(saved_handler[fill] != '0, saved_handler[fill],
						saved_context[fill], usk_pkg::ST_OK, fill == 0);
				end
			end
			usk_pkg::CMD_COMMIT: begin
				fill = 0;
				post(1'b0, '0, '0, usk_pkg::ST_OK, 1'b1);
			end
			usk_pkg::CMD_DISPOSE: begin
				p = fill - 1;
				while (p >= 0 && saved_context[p] != c.context_key)
					p--;
				if (p < 0)
					post(1'b0, '0, '0, usk_pkg::ST_NOMATCH, 1'b1);
				else begin
					h = saved_handler[p];
					k = saved_context[p];
					// close the gap, older entries keep their order
					for (int j = p; j + 1 < fill; j++) begin
						saved_handler[j] = saved_handler[j + 1];
						saved_context[j] = saved_context[j + 1];
					end
					fill--;
					post(h != '0, h, k, usk_pkg::ST_OK, 1'b1);
				end
			end
			default: ;
			endcase
		endfunction

		function void check_result(usk_pkg::res_t got);
			usk_pkg::res_t want;
			if (queued_outcomes.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected beat: %s", describe(got));
				return;
			end
			want = queued_outcomes.pop_front();
			if (got.invoke !== want.invoke || got.run_handler !== want.run_handler ||
					got.run_context !== want.run_context || got.status !== want.status ||
					got.last !== want.last || got.depth !== want.depth) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("mismatch at %0t", $realtime);
					$display("  exp %s", describe(want));
					$display("  got %s", describe(got));
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	usk_pkg::cmd_t cmd;
	logic done;
	usk_pkg::res_t res;

	undo_shadow shadow = new();
	logic [usk_pkg::CONTEXT_BITS-1:0] ctx_pool [8];
	int cycles = 0;

	undo_stack_with_keyed_removal dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// check result beats first, then log an accepted command
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				shadow.check_result(res);
			if (start && !busy)
				shadow.note_command(cmd);
		end
	end

	// all tasks enter and leave on a falling edge
	task automatic issue(input logic [1:0] op, input logic [usk_pkg::HANDLE_BITS-1:0] h,
			input logic [usk_pkg::CONTEXT_BITS-1:0] k);
		start <= 1'b1;
		cmd <= {op, h, k};
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle(input int n);
		logic [63:0] noise;
		noise = {$urandom(), $urandom()};
		start <= 1'b0;
		cmd <= noise[$bits(usk_pkg::cmd_t)-1:0];
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		@(negedge clk);
		while (shadow.queued_outcomes.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int                               push_weight;
		int                               rest;
		int                               roll;
		bit                               idle_on;
		logic [1:0]                       op;
		logic [usk_pkg::HANDLE_BITS-1:0]  h;
		logic [usk_pkg::CONTEXT_BITS-1:0] k;

		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		push_weight = 50;
		idle_on = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty stack corners
		issue(usk_pkg::CMD_ROLLBACK, '0, '0);
		issue(usk_pkg::CMD_DISPOSE, 16'h0001, 32'hFFFF_FFFF);
		issue(usk_pkg::CMD_COMMIT, 16'hFFFF, '0);
		issue(usk_pkg::CMD_PUSH, '0, 32'hFFFF_FFFF);

		// fill to the top, duplicate key on every fourth entry
		for (int i = 0; i < usk_pkg::DEPTH_DEF; i++) begin
			if (i == 0)
				issue(usk_pkg::CMD_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
			else if (i == 1)
				issue(usk_pkg::CMD_PUSH, 16'h0001, 32'h0000_0000);
			else if (i == 2)
				issue(usk_pkg::CMD_PUSH, 16'h8000, 32'h8000_0000);
			else
				issue(usk_pkg::CMD_PUSH, 16'(i * 16'h1111),
					(i % 4 == 3) ? DUP_KEY : $urandom());
		end
		issue(usk_pkg::CMD_PUSH, 16'hFFFF, '0);
		issue(usk_pkg::CMD_PUSH, '0, DUP_KEY);

		// newest match first: top, then a middle entry, then the bottom one
		issue(usk_pkg::CMD_DISPOSE, 16'h1234, DUP_KEY);
		issue(usk_pkg::CMD_DISPOSE, 16'h0000, DUP_KEY);
		issue(usk_pkg::CMD_DISPOSE, 16'hFFFF, 32'hFFFF_FFFF);
		issue(usk_pkg::CMD_ROLLBACK, 16'hFFFF, 32'hFFFF_FFFF);
		wait_quiet();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 30 == 0) begin
				case ($urandom_range(0, 2))
				0: push_weight = 45;
				1: push_weight = 65;
				default: push_weight = 90;
				endcase
				idle_on = ($urandom_range(0, 2) != 0);
			end
			if (n % 50 == 0)
				for (int j = 0; j < 8; j++)
					ctx_pool[j] = $urandom();
			if (n == RANDOM_ITEMS / 2)
				wait_quiet();
			if (idle_on && n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
				idle($urandom_range(1, 6));

			rest = 100 - push_weight;
			roll = $urandom_range(0, 99);
			if (roll < push_weight)
				op = usk_pkg::CMD_PUSH;
			else if (roll < push_weight + rest * 7 / 10)
				op = usk_pkg::CMD_DISPOSE;
			else if (roll < push_weight + rest * 17 / 20)
				op = usk_pkg::CMD_ROLLBACK;
			else
				op = usk_pkg::CMD_COMMIT;
			h = ($urandom_range(0, 24) == 0) ? '0 : 16'($urandom_range(1, 65535));
			k = ($urandom_range(0, 4) == 0) ? $urandom() : ctx_pool[$urandom_range(0, 7)];
			issue(op, h, k);
		end

		wait_quiet();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (shadow.fail_count == 0 && shadow.queued_outcomes.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
